// ===== design/gh_pkg.sv =====
// Package for the GNU hash section builder: op codes, result kinds, hash constants.
// No dependencies.
package gh_pkg;

  typedef enum logic [2:0] {
    OP_BYTE  = 3'd0,
    OP_END   = 3'd1,
    OP_LIST  = 3'd2,
    OP_RDBLM = 3'd3,
    OP_RDBKT = 3'd4,
    OP_CLEAR = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_CHAIN  = 2'd0,
    KIND_BLOOM  = 2'd1,
    KIND_BUCKET = 2'd2
  } kind_t;

  localparam logic [1:0] CFG_BUCKETS = 2'd0;
  localparam logic [1:0] CFG_WORDS   = 2'd1;
  localparam logic [1:0] CFG_SHIFT   = 2'd2;
  localparam logic [1:0] CFG_FIRST   = 2'd3;

  localparam logic [31:0] HASH_START = 32'd5381;

endpackage

// ===== design/gnu_hash_section_builder.sv =====
// GNU hash section builder: hashes names byte by byte, builds bloom and bucket words in two
// on-chip memories and emits chain words. An end of name runs three serial 32-step remainders
// (bloom word, bucket index of the current hash, bucket index of the pending hash), then a read
// and a write of both memories. A held result stalls further requests. Reset and a clear item
// sweep both memories, one entry a cycle over max(BLOOM_WORDS, BUCKETS) entries, no input
// taken. A table read passes through S_TRD and S_TOUT before its result is raised.
module gnu_hash_section_builder
  import gh_pkg::*;
#(
  parameter int BLOOM_WORDS = 64,
  parameter int BUCKETS     = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  name_byte,
  input  logic [7:0]  table_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [31:0] chain_position,
  output logic [63:0] result_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int WA  = (BLOOM_WORDS > 1) ? $clog2(BLOOM_WORDS) : 1;
  localparam int BA  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WCW = $clog2(BLOOM_WORDS + 1);
  localparam int BCW = $clog2(BUCKETS + 1);
  localparam int MW  = (WCW > BCW) ? WCW : BCW;
  localparam int SW  = (BLOOM_WORDS > BUCKETS) ? BLOOM_WORDS : BUCKETS;
  localparam int SA  = $clog2(SW + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SWEEP = 10'b0000000010,
    S_MODW  = 10'b0000000100,
    S_MODB  = 10'b0000001000,
    S_MODP  = 10'b0000010000,
    S_RD    = 10'b0000100000,
    S_WR    = 10'b0001000000,
    S_TRD   = 10'b0010000000,
    S_TOUT  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;

  logic [8:0]  bucket_count;
  logic [6:0]  bloom_word_count;
  logic [4:0]  bloom_shift;
  logic [31:0] first_symbol_index;

  logic [31:0] running_hash, pending_hash, symbol_counter, cur_hash;
  logic        pending_valid;
  logic [SA-1:0] sweep;

  logic [63:0] bloom_mem [BLOOM_WORDS];
  logic [31:0] bucket_mem [BUCKETS];
  logic [63:0] bloom_rd;
  logic [31:0] bucket_rd;
  logic [WA-1:0] w_addr;
  logic [BA-1:0] b_addr;
  logic [BA-1:0] cur_b;
  logic          rd_bloom;
  logic          rd_range;

  // effective counts
  logic [WCW-1:0] eff_words;
  logic [BCW-1:0] eff_bkts;
  always_comb begin
    if (bloom_word_count == 7'd0) eff_words = WCW'(1);
    else if (32'(bloom_word_count) > 32'(BLOOM_WORDS)) eff_words = WCW'(BLOOM_WORDS);
    else eff_words = WCW'(bloom_word_count);
    if (bucket_count == 9'd0) eff_bkts = BCW'(1);
    else if (32'(bucket_count) > 32'(BUCKETS)) eff_bkts = BCW'(BUCKETS);
    else eff_bkts = BCW'(bucket_count);
  end

  logic          m_start, m_done;
  logic [31:0]   m_dividend;
  logic [MW-1:0] m_divisor, m_rem;

  gh_mod #(.DW(MW)) u_mod (
    .clk(clk), .rst(rst), .start(m_start), .dividend(m_dividend),
    .divisor(m_divisor), .done(m_done), .remainder(m_rem)
  );

  logic accept;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= 9'd1;
      bloom_word_count <= 7'd1;
      bloom_shift <= 5'd0;
      first_symbol_index <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUCKETS: bucket_count <= cfg_data[8:0];
        CFG_WORDS:   bloom_word_count <= cfg_data[6:0];
        CFG_SHIFT:   bloom_shift <= cfg_data[4:0];
        CFG_FIRST:   first_symbol_index <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories: sweep clears, RMW writes in S_WR
  logic [63:0] bloom_bits;
  assign bloom_bits = (64'd1 << cur_hash[5:0]) | (64'd1 << (cur_hash >> bloom_shift) % 64);
  always_ff @(posedge clk) begin
    if (state == S_SWEEP) begin
      if (32'(sweep) < 32'(BLOOM_WORDS)) bloom_mem[sweep[WA-1:0]] <= '0;
      if (32'(sweep) < 32'(BUCKETS)) bucket_mem[sweep[BA-1:0]] <= '0;
    end else if (state == S_WR) begin
      bloom_mem[w_addr] <= bloom_rd | bloom_bits;
      if (bucket_rd == 32'd0) bucket_mem[cur_b] <= first_symbol_index + symbol_counter;
    end
    bloom_rd  <= bloom_mem[w_addr];
    bucket_rd <= bucket_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sweep <= '0;
      out_valid <= 1'b0;
      running_hash <= HASH_START;
      pending_valid <= 1'b0;
      symbol_counter <= '0;
      m_start <= 1'b0;
    end else begin
      m_start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          case (op)
            OP_BYTE: running_hash <= running_hash * 32'd33 + 32'(name_byte);
            OP_END: begin
              cur_hash <= running_hash;
              m_dividend <= {6'd0, running_hash[31:6]};
              m_divisor <= MW'(eff_words);
              m_start <= 1'b1;
              state <= S_MODW;
            end
            OP_LIST: begin
              if (pending_valid) begin
                out_valid <= 1'b1;
                result_kind <= KIND_CHAIN;
                chain_position <= symbol_counter - 32'd1;
                result_value <= {32'd0, pending_hash | 32'd1};
              end
              running_hash <= HASH_START;
              pending_valid <= 1'b0;
              symbol_counter <= '0;
            end
            OP_RDBLM, OP_RDBKT: begin
              rd_bloom <= (op == OP_RDBLM);
              rd_range <= (op == OP_RDBLM) ? (32'(table_index) < 32'(BLOOM_WORDS))
                                           : (32'(table_index) < 32'(BUCKETS));
              w_addr <= WA'(table_index);
              b_addr <= BA'(table_index);
              state <= S_TRD;
            end
            OP_CLEAR: begin
              running_hash <= HASH_START;
              pending_valid <= 1'b0;
              symbol_counter <= '0;
              sweep <= '0;
              state <= S_SWEEP;
            end
            default: ;
          endcase
        end
        S_SWEEP: begin
          sweep <= sweep + SA'(1);
          if (32'(sweep) == SW - 1) state <= S_IDLE;
        end
        S_MODW: if (m_done) begin
          w_addr <= WA'(m_rem);
          m_dividend <= cur_hash;
          m_divisor <= MW'(eff_bkts);
          m_start <= 1'b1;
          state <= S_MODB;
        end
        S_MODB: if (m_done) begin
          cur_b <= BA'(m_rem);
          b_addr <= BA'(m_rem);
          m_dividend <= pending_hash;
          m_start <= 1'b1;
          state <= S_MODP;
        end
        S_MODP: if (m_done) begin
          if (pending_valid) begin
            out_valid <= 1'b1;
            result_kind <= KIND_CHAIN;
            chain_position <= symbol_counter - 32'd1;
            result_value <= {32'd0, pending_hash[31:1], (BA'(m_rem) != cur_b)};
          end
          state <= S_RD;
        end
        S_RD: state <= S_WR;
        S_WR: begin
          pending_hash <= cur_hash;
          pending_valid <= 1'b1;
          symbol_counter <= symbol_counter + 32'd1;
          running_hash <= HASH_START;
          state <= S_IDLE;
        end
        S_TRD: state <= S_TOUT;
        S_TOUT: begin
          out_valid <= 1'b1;
          chain_position <= '0;
          if (rd_bloom) begin
            result_kind <= KIND_BLOOM;
            result_value <= rd_range ? bloom_rd : 64'd0;
          end else begin
            result_kind <= KIND_BUCKET;
            result_value <= rd_range ? {32'd0, bucket_rd} : 64'd0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // out_valid is only raised from IDLE/MODP/TOUT, never while a result is still held
  // (in_stall covers IDLE; MODP/TOUT are entered only after the output drained).
  // S_OUT is a spare code kept out of reach.
  assert property (@(posedge clk) disable iff (rst) state != S_OUT)
    else $error("unreachable state");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |=> (state == S_IDLE && pending_valid))
    else $error("end of name did not commit");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(result_value))
    else $error("stalled result changed");
endmodule

// ===== design/gh_mod.sv =====
// Sequential modulo unit: remainder of a 32-bit value by a divisor, one bit a cycle.
// Depends on nothing but its ports.
module gh_mod #(
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] remainder
);
  logic [31:0] shreg;
  logic [DW:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [DW:0] trial;

  always_comb begin
    trial = {rem[DW-1:0], shreg[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[30:0], 1'b0};
      if (trial >= {1'b0, divisor}) rem <= trial - {1'b0, divisor};
      else rem <= trial;
    end
  end

  assign remainder = rem[DW-1:0];
endmodule

// ===== tb/gnu_hash_section_checker.sv =====
// Checker for the GNU hash section builder: watches request and result channels,
// predicts table and chain words, compares them. Depends on gh_pkg.
`timescale 1ns / 100ps
module gnu_hash_section_checker
  import gh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  name_byte,
  input  logic [7:0]  table_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  result_kind,
  input  logic [31:0] chain_position,
  input  logic [63:0] result_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_results,
  output int          chain_seen,
  output int          table_seen
);

  typedef struct packed {
    kind_t       kind;
    logic [31:0] pos;
    logic [63:0] value;
  } table_word_t;

  table_word_t expected_words[$];

  logic [8:0]  bucket_cnt;
  logic [6:0]  word_cnt;
  logic [4:0]  shift_amt;
  logic [31:0] first_index;
  logic [31:0] name_hash;
  logic        prev_valid;
  logic [31:0] prev_hash;
  logic [31:0] sym_count;
  logic [63:0] bloom_words[64];
  logic [31:0] bucket_words[256];

  function automatic logic [31:0] live_buckets();
    if (bucket_cnt == 0) return 1;
    if (bucket_cnt > 256) return 256;
    return bucket_cnt;
  endfunction

  function automatic logic [31:0] live_words();
    if (word_cnt == 0) return 1;
    if (word_cnt > 64) return 64;
    return word_cnt;
  endfunction

  task automatic restart_list();
    name_hash = HASH_START;
    prev_valid = 0;
    prev_hash = 0;
    sym_count = 0;
  endtask

  task automatic predict_request(input logic [2:0] code, input logic [7:0] data,
                                 input logic [7:0] idx);
    logic [31:0] nb, w, b;
    table_word_t t;
    case (code)
      OP_BYTE: name_hash = name_hash * 33 + data;
      OP_END: begin
        nb = live_buckets();
        w = (name_hash / 64) % live_words();
        b = name_hash % nb;
        bloom_words[w] |= (64'd1 << name_hash[5:0]) | (64'd1 << ((name_hash >> shift_amt) & 63));
        if (bucket_words[b] == 0) bucket_words[b] = first_index + sym_count;
        if (prev_valid) begin
          t.kind = KIND_CHAIN;
          t.pos = sym_count - 1;
          t.value = {32'd0, prev_hash[31:1], ((prev_hash % nb) != b) ? 1'b1 : 1'b0};
          expected_words.push_back(t);
        end
        prev_hash = name_hash;
        prev_valid = 1;
        sym_count = sym_count + 1;
        name_hash = HASH_START;
      end
      OP_LIST: begin
        if (prev_valid) begin
          t.kind = KIND_CHAIN;
          t.pos = sym_count - 1;
          t.value = {32'd0, prev_hash | 32'd1};
          expected_words.push_back(t);
        end
        restart_list();
      end
      OP_RDBLM: begin
        t.kind = KIND_BLOOM;
        t.pos = 0;
        t.value = (idx < 64) ? bloom_words[idx[5:0]] : 64'd0;
        expected_words.push_back(t);
      end
      OP_RDBKT: begin
        t.kind = KIND_BUCKET;
        t.pos = 0;
        t.value = {32'd0, bucket_words[idx]};
        expected_words.push_back(t);
      end
      OP_CLEAR: begin
        foreach (bloom_words[i]) bloom_words[i] = 0;
        foreach (bucket_words[i]) bucket_words[i] = 0;
        restart_list();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    table_word_t t;
    if (rst) begin
      bucket_cnt = 1;
      word_cnt = 1;
      shift_amt = 0;
      first_index = 1;
      restart_list();
      foreach (bloom_words[i]) bloom_words[i] = 0;
      foreach (bucket_words[i]) bucket_words[i] = 0;
      expected_words.delete();
      fail_count = 0;
      chain_seen = 0;
      table_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUCKETS: bucket_cnt = cfg_data[8:0];
          CFG_WORDS:   word_cnt = cfg_data[6:0];
          CFG_SHIFT:   shift_amt = cfg_data[4:0];
          CFG_FIRST:   first_index = cfg_data;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result kind=%0d value=%h", result_kind, result_value);
          fail_count++;
        end else begin
          t = expected_words.pop_front();
          if (result_kind != t.kind) begin
            $error("result_kind: expected %0d, got %0d", t.kind, result_kind);
            fail_count++;
          end
          if (chain_position != t.pos) begin
            $error("chain_position: expected %0d, got %0d", t.pos, chain_position);
            fail_count++;
          end
          if (result_value != t.value) begin
            $error("result_value: expected %h, got %h", t.value, result_value);
            fail_count++;
          end
          if (t.kind == KIND_CHAIN) chain_seen++;
          else table_seen++;
        end
      end
      if (in_valid && !in_stall) predict_request(op, name_byte, table_index);
    end
    pending_results = expected_words.size();
  end

endmodule

// ===== tb/gnu_hash_section_builder_test.sv =====
// Top of the GNU hash section builder testbench: clock, reset, stimulus and verdict.
// Depends on gh_pkg, gnu_hash_section_builder and gnu_hash_section_checker.
`timescale 1ns / 100ps
module gnu_hash_section_builder_test;
  import gh_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  op = OP_BYTE;
  logic [7:0]  name_byte = 0;
  logic [7:0]  table_index = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  result_kind;
  logic [31:0] chain_position;
  logic [63:0] result_value;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = CFG_BUCKETS;
  logic [31:0] cfg_data = 0;
  int          fail_count, pending_results, chain_seen, table_seen;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          cycle_count = 0;
  int          sent_count = 0;

  gnu_hash_section_builder DUT (.*);
  gnu_hash_section_checker checker_i (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one request; random sender gaps before it; in_valid stays up after the accept
  // until the next request, a gap or drain() takes it over
  task automatic send(input logic [2:0] code, input logic [7:0] data, input logic [7:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    op <= code;
    name_byte <= data;
    table_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_results != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] nb, input logic [31:0] nw,
                          input logic [31:0] sh, input logic [31:0] first);
    drain();
    write_reg(CFG_BUCKETS, nb);
    write_reg(CFG_WORDS, nw);
    write_reg(CFG_SHIFT, sh);
    write_reg(CFG_FIRST, first);
    cfg_we <= 0;
  endtask

  task automatic send_name(input int len);
    repeat (len) send(OP_BYTE, $urandom_range(255), 0);
    send(OP_END, 0, 0);
  endtask

  // names come out sorted by bucket only by chance; table contents still follow the rule
  task automatic random_phase(input int count);
    int target, r;
    target = sent_count + count;
    while (sent_count < target) begin
      r = $urandom_range(99);
      if (r < 55) send_name($urandom_range(1, 6));
      else if (r < 62) send(OP_LIST, 0, 0);
      else if (r < 75) send(OP_RDBLM, 0, $urandom_range(99) < 80 ? $urandom_range(63)
                                                              : $urandom_range(255));
      else if (r < 88) send(OP_RDBKT, 0, $urandom_range(255));
      else if (r < 90) send(OP_CLEAR, 0, 0);
      else if (r < 92) send($urandom_range(6, 7), $urandom_range(255), $urandom_range(255));
      else send(OP_BYTE, $urandom_range(255), 0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset settings, empty list end, extreme bytes, reads out of range, unused op codes, clear
    send(OP_LIST, 0, 0);
    send(OP_BYTE, 8'h00, 0);
    send(OP_BYTE, 8'hFF, 0);
    send(OP_END, 0, 0);
    send(OP_END, 0, 0);
    send(OP_BYTE, 8'h55, 0);
    send(OP_LIST, 0, 0);
    send(OP_RDBLM, 0, 0);
    send(OP_RDBLM, 0, 8'hFF);
    send(OP_RDBKT, 0, 0);
    send(OP_RDBKT, 0, 8'hAA);
    send(6, 8'hFF, 8'hFF);
    send(7, 8'h00, 8'h00);
    send(OP_CLEAR, 0, 0);
    send(OP_RDBKT, 0, 0);
    // zero counts act as 1; first index wraps around
    set_regs(0, 0, 31, 32'hFFFF_FFFF);
    send(OP_BYTE, 8'hA5, 0);
    send(OP_END, 0, 0);
    send(OP_END, 0, 0);
    send(OP_LIST, 0, 0);
    send(OP_RDBKT, 0, 0);
    send(OP_RDBLM, 0, 0);
    // oversized counts saturate
    set_regs(511, 127, 5, 0);
    send_name(3);
    send_name(2);
    send(OP_LIST, 0, 0);

    send_idle_pct = 23; recv_idle_pct = 84;
    set_regs(256, 64, 0, 1);
    random_phase(220);
    send_name(2);
    drain(); // sender holds off until everything is back
    send_idle_pct = 84; recv_idle_pct = 23;
    set_regs(7, 3, 13, 32'h8000_0000);
    random_phase(200);
    send_idle_pct = 0; recv_idle_pct = 0;
    set_regs(1, 1, 31, 32'hFFFF_FFF0);
    random_phase(100);
    set_regs(200, 40, 17, 12345);
    random_phase(120);
    send(OP_LIST, 0, 0);

    drain();
    $display("Sent %0d requests; checked %0d chain words and %0d table reads.",
             sent_count, chain_seen, table_seen);
    if (fail_count == 0 && pending_results == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
